FILE: design/pcet_pkg.sv
package pcet_pkg;

    localparam int unsigned PHASE_W     = 16;
    localparam int unsigned TIME_W      = 56;
    localparam int unsigned PERIOD_W    = 32;
    localparam int unsigned CORDIC_W    = 18;
    localparam int unsigned CORDIC_STEPS = 15;
    // scale of the reciprocal used for the sine bin index
    localparam int unsigned BIN_SHIFT   = 28;

    localparam logic [PHASE_W-1:0] TWO_PI_Q13 = 16'd51472;
    localparam logic [PHASE_W-1:0] PHASE_MAX  = 16'd51471;
    localparam logic signed [CORDIC_W-1:0] CORDIC_START = 18'sd9949;
    localparam logic signed [CORDIC_W-1:0] SINE_POS_MAX = 18'sd16384;
    localparam logic signed [CORDIC_W-1:0] SINE_NEG_MAX = -18'sd16384;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE      = 2'd0;
    localparam logic [1:0] CFG_PERIOD    = 2'd1;
    localparam logic [1:0] CFG_PARITY    = 2'd2;
    localparam logic [1:0] CFG_THRESHOLD = 2'd3;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_sample;
        logic               new_series;
    } t_in_req;

    typedef struct packed {
        logic [TIME_W-1:0] event_time;
        logic [TIME_W-1:0] interval;
        logic              interval_valid;
    } t_out_req;

    // arctangent of 2^-i in 16-bit turn units
    function automatic logic signed [CORDIC_W-1:0] atan_turns(input logic [3:0] i);
        logic signed [CORDIC_W-1:0] v;
        unique case (i)
            4'd0:    v = 18'sd8192;
            4'd1:    v = 18'sd4836;
            4'd2:    v = 18'sd2555;
            4'd3:    v = 18'sd1297;
            4'd4:    v = 18'sd651;
            4'd5:    v = 18'sd326;
            4'd6:    v = 18'sd163;
            4'd7:    v = 18'sd81;
            4'd8:    v = 18'sd41;
            4'd9:    v = 18'sd20;
            4'd10:   v = 18'sd10;
            4'd11:   v = 18'sd5;
            4'd12:   v = 18'sd3;
            4'd13:   v = 18'sd1;
            4'd14:   v = 18'sd1;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: design/pcet_stream_if.sv
interface pcet_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: design/phase_crossing_event_timer_unit.sv
// interpolated crossing timer for one phase stream
// i_in carries requests of one phase sample (Q3.13 rad) plus a new_series flag;
// o_out carries one request per kept crossing: event time, interval since the
// previous kept event and a flag telling whether that interval exists.
// configuration goes through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// writes it only while idle, which the block itself does not enforce.
// the block takes one request at a time; i_in.ready is high only when idle.
// first sample of a series, or phase mode without a wrap: no result, idle.
// phase mode wrap: 16 divider steps, then ST_MUL1, ST_MUL2 and ST_DONE.
// phase mode wrap onto phase zero: the fraction saturates without a divide.
// amplitude mode: two sines (bin index, 15 rotations each), then for a kept
// crossing the divide, ST_MUL1, ST_MUL2 and ST_DONE.
// the datapath has a reciprocal bin multiply, a shared cordic rotator, a
// restoring divider and a single 32x32 multiplier.
// a finished result sits in the output register; a new sample may be taken
// while it waits, and the next result waits until the receiver drains it.
// reset (synchronous, active low) restores register defaults and empties the
// series history and the output register.
module phase_crossing_event_timer_unit #(
    parameter int unsigned INDEX_BITS      = 24,
    parameter int unsigned SINE_TABLE_BITS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    pcet_stream_if.sink                     i_in,
    pcet_stream_if.source                   o_out,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_idx,
    input  logic [31:0]                     i_cfg_data
);
    import pcet_pkg::*;

    localparam int unsigned DEN_W = PHASE_W + 1;
    localparam int unsigned CNT_W = 5;
    localparam int unsigned BIN_PROD_W = PHASE_W + 32;
    // ceil(2^(BIN_SHIFT+B) / 2pi): exact bin index for every phase in range
    localparam logic [31:0] BIN_RECIP = 32'(((64'd1 << (BIN_SHIFT + SINE_TABLE_BITS))
                                             + 64'(TWO_PI_Q13) - 64'd1) / 64'(TWO_PI_Q13));

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_BIN    = 7'b0000010,
        ST_CORDIC = 7'b0000100,
        ST_DIVF   = 7'b0001000,
        ST_MUL1   = 7'b0010000,
        ST_MUL2   = 7'b0100000,
        ST_DONE   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic                r_mode;
    logic [PERIOD_W-1:0] r_period;
    logic                r_start_parity;
    logic [PHASE_W-1:0]  r_threshold;

    // series history
    logic [PHASE_W-1:0]    r_prev_phase, n_prev_phase;
    logic                  r_have_prev, n_have_prev;
    logic [INDEX_BITS-1:0] r_index, n_index;
    logic                  r_parity, n_parity;
    logic [TIME_W-1:0]     r_last_time, n_last_time;
    logic                  r_have_event, n_have_event;

    // per-sample working registers
    logic [PHASE_W-1:0]    r_y1, n_y1;
    logic [PHASE_W-1:0]    r_cur, n_cur;
    logic [INDEX_BITS-1:0] r_j, n_j;
    logic                  r_second, n_second;
    logic signed [CORDIC_W-1:0] r_a1, n_a1;
    logic [PHASE_W-1:0]    r_frac, n_frac;

    // shared divider
    logic [DEN_W-1:0]   r_rem, n_rem;
    logic [DEN_W-1:0]   r_den, n_den;
    logic [PHASE_W-1:0] r_quo, n_quo;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    // shared cordic
    logic signed [CORDIC_W-1:0] r_x, n_x, r_y, n_y, r_z, n_z;
    logic [3:0] r_i, n_i;

    // time product
    logic [TIME_W-1:0] r_prod, n_prod;
    logic [TIME_W-1:0] r_prod2, n_prod2;

    // output register
    logic     r_out_valid, n_out_valid;
    t_out_req r_out, n_out;

    // combinational helpers
    logic [PHASE_W-1:0] cur_clamped;
    logic [DEN_W:0]     div_shift;
    logic               div_ge;
    logic [PHASE_W-1:0] diff;
    logic [PHASE_W-1:0] wrap_num;
    logic [PHASE_W-1:0] bin_phase;
    logic [BIN_PROD_W-1:0] bin_prod;
    logic [SINE_TABLE_BITS-1:0] bin_k;
    logic [PHASE_W-1:0] turn_u;
    logic signed [CORDIC_W-1:0] z_raw, z_fold;
    logic signed [CORDIC_W-1:0] dx, dy, atan_i;
    logic signed [CORDIC_W-1:0] sine_y;
    logic signed [CORDIC_W-1:0] abs_a1, abs_a2;
    logic [PERIOD_W-1:0] mul_a;
    logic [2*PERIOD_W-1:0] mul_p;
    logic [TIME_W-1:0] event_t;

    assign cur_clamped = (i_in.data.phase_sample > PHASE_MAX) ? PHASE_MAX
                                                              : i_in.data.phase_sample;
    assign diff     = (r_prev_phase > cur_clamped) ? (r_prev_phase - cur_clamped)
                                                   : (cur_clamped - r_prev_phase);
    assign wrap_num = TWO_PI_Q13 - r_prev_phase;

    // restoring divider step
    assign div_shift = {r_rem, 1'b0};
    assign div_ge    = div_shift >= {1'b0, r_den};

    // sine bin index by reciprocal multiply
    assign bin_phase = r_second ? r_cur : r_y1;
    assign bin_prod  = BIN_PROD_W'(bin_phase) * BIN_PROD_W'(BIN_RECIP);
    assign bin_k     = bin_prod[BIN_SHIFT +: SINE_TABLE_BITS];

    // sine bin center as a signed turn, folded into the right half plane
    assign turn_u = PHASE_W'({bin_k, 1'b1}) << (15 - SINE_TABLE_BITS);
    assign z_raw  = CORDIC_W'(signed'(turn_u));
    always_comb begin
        if (z_raw > 18'sd16384) begin
            z_fold = 18'sd32768 - z_raw;
        end else if (z_raw < -18'sd16384) begin
            z_fold = -18'sd32768 - z_raw;
        end else begin
            z_fold = z_raw;
        end
    end

    // cordic rotation step
    assign dx     = r_y >>> r_i;
    assign dy     = r_x >>> r_i;
    assign atan_i = atan_turns(r_i);

    // sine clamped to one in Q1.14, using the finishing step's values
    always_comb begin
        logic signed [CORDIC_W-1:0] y_last;
        y_last = (r_z >= 0) ? (r_y + dy) : (r_y - dy);
        if (y_last > SINE_POS_MAX) begin
            sine_y = SINE_POS_MAX;
        end else if (y_last < SINE_NEG_MAX) begin
            sine_y = SINE_NEG_MAX;
        end else begin
            sine_y = y_last;
        end
    end

    assign abs_a1 = (r_a1 < 0) ? -r_a1 : r_a1;
    assign abs_a2 = (sine_y < 0) ? -sine_y : sine_y;

    // one multiplier shared by both time products
    assign mul_a = r_state[4] ? PERIOD_W'(r_j) : PERIOD_W'(r_frac);
    assign mul_p = mul_a * r_period;

    assign event_t = r_prod + r_prod2;

    assign i_in.ready = (r_state == ST_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_comb begin
        n_state      = r_state;
        n_prev_phase = r_prev_phase;
        n_have_prev  = r_have_prev;
        n_index      = r_index;
        n_parity     = r_parity;
        n_last_time  = r_last_time;
        n_have_event = r_have_event;
        n_y1         = r_y1;
        n_cur        = r_cur;
        n_j          = r_j;
        n_second     = r_second;
        n_a1         = r_a1;
        n_frac       = r_frac;
        n_rem        = r_rem;
        n_den        = r_den;
        n_quo        = r_quo;
        n_cnt        = r_cnt;
        n_x          = r_x;
        n_y          = r_y;
        n_z          = r_z;
        n_i          = r_i;
        n_prod       = r_prod;
        n_prod2      = r_prod2;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out        = r_out;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_prev_phase = cur_clamped;
                    n_have_prev  = 1'b1;
                    if (i_in.data.new_series || !r_have_prev) begin
                        n_index      = '0;
                        n_parity     = 1'b0;
                        n_have_event = 1'b0;
                    end else begin
                        n_index = r_index + 1'b1;
                        n_y1    = r_prev_phase;
                        n_cur   = cur_clamped;
                        n_j     = r_index;
                        if (r_mode) begin
                            if (diff > r_threshold) begin
                                if (cur_clamped == '0) begin
                                    // numerator equals denominator: saturate
                                    n_frac  = '1;
                                    n_state = ST_MUL1;
                                end else begin
                                    n_rem   = DEN_W'(wrap_num);
                                    n_den   = DEN_W'(wrap_num) + DEN_W'(cur_clamped);
                                    n_quo   = '0;
                                    n_cnt   = CNT_W'(PHASE_W);
                                    n_state = ST_DIVF;
                                end
                            end
                        end else begin
                            // sine of the previous sample first
                            n_second = 1'b0;
                            n_state  = ST_BIN;
                        end
                    end
                end
            end
            ST_BIN: begin
                n_x     = CORDIC_START;
                n_y     = '0;
                n_z     = z_fold;
                n_i     = '0;
                n_state = ST_CORDIC;
            end
            ST_DIVF: begin
                n_rem = div_ge ? DEN_W'(div_shift - {1'b0, r_den}) : DEN_W'(div_shift);
                n_quo = {r_quo[PHASE_W-2:0], div_ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_frac  = {r_quo[PHASE_W-2:0], div_ge};
                    n_state = ST_MUL1;
                end
            end
            ST_CORDIC: begin
                if (r_z >= 0) begin
                    n_x = r_x - dx;
                    n_y = r_y + dy;
                    n_z = r_z - atan_i;
                end else begin
                    n_x = r_x + dx;
                    n_y = r_y - dy;
                    n_z = r_z + atan_i;
                end
                n_i = r_i + 1'b1;
                if (r_i == 4'(CORDIC_STEPS - 1)) begin
                    if (!r_second) begin
                        n_a1     = sine_y;
                        n_second = 1'b1;
                        n_state  = ST_BIN;
                    end else if ((r_a1 < 0 && sine_y > 0) || (r_a1 > 0 && sine_y < 0)) begin
                        n_parity = ~r_parity;
                        if (r_parity == r_start_parity) begin
                            n_rem   = DEN_W'(abs_a1);
                            n_den   = DEN_W'(abs_a1) + DEN_W'(abs_a2);
                            n_quo   = '0;
                            n_cnt   = CNT_W'(PHASE_W);
                            n_state = ST_DIVF;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_MUL1: begin
                n_prod  = mul_p[TIME_W-1:0];
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                n_prod2 = TIME_W'(mul_p >> PHASE_W);
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // wait for a free output slot
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid              = 1'b1;
                    n_out.event_time         = event_t;
                    n_out.interval           = r_have_event ? (event_t - r_last_time) : '0;
                    n_out.interval_valid     = r_have_event;
                    n_last_time              = event_t;
                    n_have_event             = 1'b1;
                    n_state                  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_mode         <= 1'b0;
            r_period       <= 32'd65536;
            r_start_parity <= 1'b0;
            r_threshold    <= 16'd49152;
            r_prev_phase   <= '0;
            r_have_prev    <= 1'b0;
            r_index        <= '0;
            r_parity       <= 1'b0;
            r_last_time    <= '0;
            r_have_event   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_prev_phase <= n_prev_phase;
            r_have_prev  <= n_have_prev;
            r_index      <= n_index;
            r_parity     <= n_parity;
            r_last_time  <= n_last_time;
            r_have_event <= n_have_event;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MODE:      r_mode         <= i_cfg_data[0];
                    CFG_PERIOD:    r_period       <= i_cfg_data;
                    CFG_PARITY:    r_start_parity <= i_cfg_data[0];
                    CFG_THRESHOLD: r_threshold    <= i_cfg_data[PHASE_W-1:0];
                    default:       r_mode         <= r_mode;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_y1     <= n_y1;
        r_cur    <= n_cur;
        r_j      <= n_j;
        r_second <= n_second;
        r_a1     <= n_a1;
        r_frac   <= n_frac;
        r_rem    <= n_rem;
        r_den    <= n_den;
        r_quo    <= n_quo;
        r_cnt    <= n_cnt;
        r_x      <= n_x;
        r_y      <= n_y;
        r_z      <= n_z;
        r_i      <= n_i;
        r_prod   <= n_prod;
        r_prod2  <= n_prod2;
        r_out    <= n_out;
    end

endmodule

FILE: bench/pcet_tb_if.sv
`timescale 1ns / 1ps
// (testbench uses the design's pcet_stream_if; this file carries no extra interface)
package pcet_tb_util;
    localparam int unsigned SETTLE_CYCLES = 120;
endpackage

FILE: bench/tb.sv
`timescale 1ns / 1ps
module tb;
    import pcet_pkg::*;

    localparam int unsigned IDX_BITS  = 24;
    localparam int unsigned SIN_BITS  = 10;
    localparam int unsigned WATCHDOG  = 20000;
    localparam int unsigned RAND_ITEMS = 1320;
    localparam logic [31:0] PERIODS [6] = '{32'd65536, 32'hFFFFFFFF, 32'd1, 32'd0,
                                            32'h0003_8000, 32'h1234_5678};

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} t_idle;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [31:0] i_cfg_data;

    pcet_stream_if #(.T(t_in_req))  in_if ();
    pcet_stream_if #(.T(t_out_req)) out_if ();

    phase_crossing_event_timer_unit #(
        .INDEX_BITS(IDX_BITS),
        .SINE_TABLE_BITS(SIN_BITS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_if.sink),
        .o_out(out_if.source),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    // predictor copy of configuration and series history
    logic        cfg_mode;
    logic [31:0] cfg_period;
    logic        cfg_parity;
    logic [15:0] cfg_thresh;
    logic [15:0] hist_phase;
    logic        hist_valid;
    logic [IDX_BITS-1:0] hist_index;
    logic        hist_parity;
    logic [55:0] hist_event_time;
    logic        hist_have_event;

    t_in_req  sample_queue[$];
    t_out_req crossing_queue[$];
    t_idle    idle_phase;
    int       fail_count;
    int       quiet_cycles;
    logic     feeding;

    int signed atan_tab[15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20,
                                10, 5, 3, 1, 1};

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // quantized sine of a phase, q1.14, via the gain-compensated rotator
    function automatic int signed phase_sine(input logic [15:0] ph);
        logic [31:0] bin;
        logic [31:0] turn;
        int signed z;
        int signed x;
        int signed y;
        int signed dx;
        int signed dy;
        bin = ({16'd0, ph} << SIN_BITS) / 32'd51472;
        turn = (((bin << 1) + 32'd1) << (15 - SIN_BITS)) & 32'hFFFF;
        z = (turn >= 32768) ? int'(turn) - 65536 : int'(turn);
        x = 9949;
        y = 0;
        if (z > 16384) z = 32768 - z;
        else if (z < -16384) z = -32768 - z;
        for (int i = 0; i < 15; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        if (y > 16384) y = 16384;
        if (y < -16384) y = -16384;
        return y;
    endfunction

    function automatic logic [15:0] crossing_fraction(input logic [31:0] num,
                                                     input logic [31:0] den);
        logic [63:0] q;
        q = ({32'd0, num} << 16) / {32'd0, den};
        return (q > 64'd65535) ? 16'hFFFF : q[15:0];
    endfunction

    // advance the predicted history by one sample, queue a crossing if one is kept
    task automatic predict_crossing(input t_in_req req);
        logic [15:0] cur;
        logic [15:0] y1;
        logic [IDX_BITS-1:0] j;
        logic hit;
        logic [15:0] frac;
        logic [15:0] diff;
        logic [31:0] num;
        int signed a1;
        int signed a2;
        logic [63:0] t;
        t_out_req r;
        cur = (req.phase_sample > 16'd51471) ? 16'd51471 : req.phase_sample;
        y1 = hist_phase;
        j = hist_index;
        hit = 1'b0;
        frac = '0;
        if (req.new_series || !hist_valid) begin
            hist_phase = cur;
            hist_valid = 1'b1;
            hist_index = '0;
            hist_parity = 1'b0;
            hist_have_event = 1'b0;
            return;
        end
        hist_phase = cur;
        hist_index = j + 1'b1;
        if (cfg_mode) begin
            diff = (y1 > cur) ? y1 - cur : cur - y1;
            if (diff > cfg_thresh) begin
                num = 32'd51472 - {16'd0, y1};
                frac = crossing_fraction(num, num + {16'd0, cur});
                hit = 1'b1;
            end
        end else begin
            a1 = phase_sine(y1);
            a2 = phase_sine(cur);
            if ((a1 < 0 && a2 > 0) || (a1 > 0 && a2 < 0)) begin
                if (hist_parity == cfg_parity) begin
                    frac = crossing_fraction((a1 < 0) ? -a1 : a1,
                                             (a1 > a2) ? a1 - a2 : a2 - a1);
                    hit = 1'b1;
                end
                hist_parity = ~hist_parity;
            end
        end
        if (!hit) return;
        t = {40'd0, j} * {32'd0, cfg_period}
            + (({48'd0, frac} * {32'd0, cfg_period}) >> 16);
        r.event_time = t[55:0];
        r.interval = hist_have_event ? r.event_time - hist_event_time : '0;
        r.interval_valid = hist_have_event;
        hist_event_time = r.event_time;
        hist_have_event = 1'b1;
        crossing_queue = {crossing_queue, r};
    endtask

    task automatic report_mismatch(input string what, input logic [55:0] got,
                                   input logic [55:0] want);
        $display("tb: mismatch %s got %h want %h", what, got, want);
        fail_count++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                predict_crossing(in_if.data);
                void'(sample_queue.pop_front());
            end
            if (!in_if.valid || in_if.ready) begin
                if (feeding && sample_queue.size() > 0
                    && !((idle_phase == IDLE_SRC && $urandom_range(99) < 60) ||
                         (idle_phase == IDLE_BOTH && $urandom_range(99) < 7))) begin
                    in_if.valid <= 1'b1;
                    in_if.data <= sample_queue[0];
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor, receiver stalls
    always @(posedge i_clk) begin
        t_out_req want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (crossing_queue.size() == 0) begin
                    report_mismatch("unexpected crossing", out_if.data.event_time, '0);
                end else begin
                    want = crossing_queue.pop_front();
                    if (out_if.data.event_time !== want.event_time)
                        report_mismatch("event_time", out_if.data.event_time,
                                        want.event_time);
                    if (out_if.data.interval !== want.interval)
                        report_mismatch("interval", out_if.data.interval, want.interval);
                    if (out_if.data.interval_valid !== want.interval_valid)
                        report_mismatch("interval_valid", 56'(out_if.data.interval_valid),
                                        56'(want.interval_valid));
                end
            end
            out_if.ready <= !((idle_phase == IDLE_SNK && $urandom_range(99) < 60) ||
                              (idle_phase == IDLE_BOTH && $urandom_range(99) < 7));
        end
    end

    // watchdog on cycles with no request moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
            || !feeding)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MODE:      cfg_mode = val[0];
            CFG_PERIOD:    cfg_period = val;
            CFG_PARITY:    cfg_parity = val[0];
            CFG_THRESHOLD: cfg_thresh = val[15:0];
            default: ;
        endcase
    endtask

    // run the queued samples through and wait until every crossing is back
    task automatic run_batch();
        int guard;
        feeding = 1'b1;
        guard = 0;
        while ((sample_queue.size() != 0 || crossing_queue.size() != 0 || in_if.valid)
               && guard < 2000000) begin
            @(posedge i_clk);
            guard++;
        end
        feeding = 1'b0;
        // samples that give no crossing may still be in flight
        repeat (pcet_tb_util::SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_in_req make_sample(input logic [15:0] ph, input logic ns);
        t_in_req r;
        r.phase_sample = ph;
        r.new_series = ns;
        return r;
    endfunction

    task automatic add_sample(input logic [15:0] ph, input logic ns);
        sample_queue = {sample_queue, make_sample(ph, ns)};
    endtask

    // mostly smooth ramps that wrap, with noise and restarts mixed in
    task automatic queue_random(input int count);
        logic [15:0] ph;
        int step;
        ph = 16'($urandom_range(51471));
        step = $urandom_range(6000, 200);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 8) begin
                add_sample(16'($urandom()), 1'($urandom_range(1)));
            end else begin
                if ($urandom_range(99) < 3) step = $urandom_range(12000, 50);
                ph = 16'((int'(ph) + step) % 51472);
                add_sample(ph, $urandom_range(99) < 2);
            end
        end
    endtask

    initial begin
        fail_count = 0;
        feeding = 1'b0;
        idle_phase = IDLE_NONE;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
        cfg_mode = 1'b0;
        cfg_period = 32'd65536;
        cfg_parity = 1'b0;
        cfg_thresh = 16'd49152;
        hist_phase = '0;
        hist_valid = 1'b0;
        hist_index = '0;
        hist_parity = 1'b0;
        hist_event_time = '0;
        hist_have_event = 1'b0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: defaults, amplitude mode crossings around pi and 2pi
        add_sample(16'd0, 1'b1);
        add_sample(16'd20000, 1'b0);
        add_sample(16'd30000, 1'b0);
        add_sample(16'd51471, 1'b0);
        add_sample(16'd100, 1'b0);
        add_sample(16'hFFFF, 1'b0);   // out of range phase
        add_sample(16'd25736, 1'b0);  // near zero sine
        add_sample(16'd30000, 1'b0);
        run_batch();

        // directed: phase mode, wrap edges and threshold extremes
        write_register(CFG_MODE, 32'd1);
        write_register(CFG_THRESHOLD, 32'd0);
        write_register(CFG_PERIOD, 32'hFFFFFFFF);
        write_register(CFG_PARITY, 32'd1);
        add_sample(16'd51471, 1'b1);
        add_sample(16'd0, 1'b0);
        add_sample(16'd0, 1'b0);
        add_sample(16'd1, 1'b0);
        add_sample(16'hFFFF, 1'b0);
        run_batch();
        write_register(CFG_THRESHOLD, 32'd51471);
        write_register(CFG_PERIOD, 32'd0);
        add_sample(16'd0, 1'b0);
        add_sample(16'd51471, 1'b0);
        add_sample(16'd0, 1'b0);
        write_register(CFG_MODE, 32'd1);
        run_batch();

        // random phases over modes, periods and idling styles
        for (int ph = 0; ph < 12; ph++) begin
            idle_phase = t_idle'(ph % 4);
            write_register(CFG_MODE, 32'(ph % 3 == 2));
            write_register(CFG_PERIOD, PERIODS[ph % 6]);
            write_register(CFG_PARITY, 32'((ph / 2) % 2));
            write_register(CFG_THRESHOLD, (ph % 4 == 3) ? $urandom_range(51471)
                                          : 32'd49152 - $urandom_range(20000));
            queue_random(RAND_ITEMS / 12);
            run_batch();
        end

        if (sample_queue.size() == 0 && crossing_queue.size() == 0 && fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
